>>> hdl/cwb_pkg.sv
// shared constants and controller/datapath types for the white balance averager
package cwb_pkg;

  localparam int CHANNEL_BITS_DEF = 16;
  localparam int MAX_RUN_DEF      = 255;

  localparam int NCH        = 3;
  localparam int CH_W       = 2;
  localparam int SUM_W      = 24;
  localparam int WHITE_W    = 16;
  localparam int LEN_W      = 8;
  localparam int LEVEL_W    = 8;
  localparam int FULL_SCALE = 255;

  // measurement divider operands: numerator 510*sum + d, divisor 2*d with d = len*white
  localparam int PROD_W = SUM_W + 9;
  localparam int D_W    = LEN_W + WHITE_W;
  localparam int NUM_W  = PROD_W + 1;
  localparam int DEN_W  = D_W + 1;
  localparam int REM_W  = DEN_W + 1;
  localparam int ITER_W = $clog2(NUM_W);

  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 8;
  localparam int CAL_LEN_RST  = 50;
  localparam int MEAS_LEN_RST = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_CAL_LEN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAS_LEN = 2'd1;

  localparam logic KIND_CAL  = 1'b0;
  localparam logic KIND_MEAS = 1'b1;

  typedef struct packed {
    logic            accept;
    logic            mul;
    logic            div_load;
    logic            div_step;
    logic            store;
    logic            finish;
    logic [CH_W-1:0] ch;
  } cwb_cmd_t;

  typedef struct packed {
    logic run_done;
  } cwb_stat_t;

endpackage

>>> hdl/cwb_dp.sv
// datapath: run accumulators, white store, shared restoring divider, result registers
module cwb_dp
  import cwb_pkg::*;
#(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
  parameter int MAX_RUN      = MAX_RUN_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_cmd,
  input  logic [15:0]           in_red_raw,
  input  logic [15:0]           in_green_raw,
  input  logic [15:0]           in_blue_raw,
  input  cwb_cmd_t              cmd,
  output cwb_stat_t             stat,
  output logic                  out_result_kind,
  output logic [LEVEL_W-1:0]    out_red_level,
  output logic [LEVEL_W-1:0]    out_green_level,
  output logic [LEVEL_W-1:0]    out_blue_level,
  output logic [WHITE_W-1:0]    out_white_level,
  output logic                  out_white_missing
);

  logic [LEN_W-1:0]        cal_len_r, meas_len_r, len_r;
  logic [SUM_W-1:0]        sum_r [NCH];
  logic [SUM_W-1:0]        sum_nxt [NCH];
  logic [LEN_W-1:0]        cnt_r, cnt_nxt;
  logic                    run_cmd_r;
  logic [WHITE_W-1:0]      white_r [NCH];
  logic [LEVEL_W-1:0]      level_r [NCH];
  logic [CHANNEL_BITS-1:0] raw [NCH];
  logic                    restart;
  logic [LEN_W-1:0]        len_raw, len_sel;

  logic [PROD_W-1:0]  prod_r;
  logic [D_W-1:0]     d_r;
  logic [NUM_W-1:0]   quo_r;
  logic [DEN_W-1:0]   den_r;
  logic [REM_W-1:0]   rem_r, rem_shift;
  logic               rem_ge;
  logic [SUM_W-1:0]   sel_sum;
  logic [WHITE_W-1:0] sel_white;
  logic [LEVEL_W-1:0] level_val;
  logic [WHITE_W-1:0] white_max;
  logic               white_zero;

  assign raw[0] = in_red_raw[CHANNEL_BITS-1:0];
  assign raw[1] = in_green_raw[CHANNEL_BITS-1:0];
  assign raw[2] = in_blue_raw[CHANNEL_BITS-1:0];

  // a change of command starts a fresh run with this sample
  always_comb begin
    restart = (in_cmd != run_cmd_r);
    for (int i = 0; i < NCH; i++) begin
      sum_nxt[i] = (restart ? '0 : sum_r[i]) + SUM_W'(raw[i]);
    end
    cnt_nxt = (restart ? '0 : cnt_r) + LEN_W'(1);
    len_raw = in_cmd ? meas_len_r : cal_len_r;
    if (len_raw == '0) begin
      len_sel = LEN_W'(1);
    end else if (len_raw > LEN_W'(MAX_RUN)) begin
      len_sel = LEN_W'(MAX_RUN);
    end else begin
      len_sel = len_raw;
    end
  end

  assign stat.run_done = (cnt_nxt >= len_sel);

  assign sel_sum   = sum_r[cmd.ch];
  assign sel_white = white_r[cmd.ch];
  assign rem_shift = {rem_r[REM_W-2:0], quo_r[NUM_W-1]};
  assign rem_ge    = (rem_shift >= REM_W'(den_r));

  // quotient above full scale or missing white saturates
  assign level_val = ((sel_white == '0) || (|quo_r[NUM_W-1:LEVEL_W])) ?
                     LEVEL_W'(FULL_SCALE) : quo_r[LEVEL_W-1:0];

  always_comb begin
    white_max = white_r[0];
    if (white_r[1] > white_max) white_max = white_r[1];
    if (white_r[2] > white_max) white_max = white_r[2];
    white_zero = (white_r[0] == '0) || (white_r[1] == '0) || (white_r[2] == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_len_r  <= LEN_W'(CAL_LEN_RST);
      meas_len_r <= LEN_W'(MEAS_LEN_RST);
      cnt_r      <= '0;
      run_cmd_r  <= KIND_CAL;
      for (int i = 0; i < NCH; i++) begin
        sum_r[i]   <= '0;
        white_r[i] <= '0;
      end
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_CAL_LEN:  cal_len_r  <= cfg_data;
          CFG_MEAS_LEN: meas_len_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.accept) begin
        cnt_r     <= cnt_nxt;
        run_cmd_r <= in_cmd;
        for (int i = 0; i < NCH; i++) sum_r[i] <= sum_nxt[i];
      end
      if (cmd.store && (run_cmd_r == KIND_CAL)) begin
        white_r[cmd.ch] <= quo_r[WHITE_W-1:0];
      end
      if (cmd.finish) begin
        cnt_r <= '0;
        for (int i = 0; i < NCH; i++) sum_r[i] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      len_r <= len_sel;
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'(PROD_W'(sel_sum) * PROD_W'(2 * FULL_SCALE));
      d_r    <= D_W'(D_W'(len_r) * D_W'(sel_white));
    end
    if (cmd.div_load) begin
      rem_r <= '0;
      if (run_cmd_r == KIND_MEAS) begin
        // +d before dividing by 2d rounds half up
        quo_r <= NUM_W'(prod_r) + NUM_W'(d_r);
        den_r <= {d_r, 1'b0};
      end else begin
        quo_r <= NUM_W'(sel_sum);
        den_r <= DEN_W'(len_r);
      end
    end
    if (cmd.div_step) begin
      rem_r <= rem_ge ? (rem_shift - REM_W'(den_r)) : rem_shift;
      quo_r <= {quo_r[NUM_W-2:0], rem_ge};
    end
    if (cmd.store && (run_cmd_r == KIND_MEAS)) begin
      level_r[cmd.ch] <= level_val;
    end
    if (cmd.finish) begin
      out_result_kind   <= run_cmd_r;
      out_red_level     <= (run_cmd_r == KIND_MEAS) ? level_r[0] : '0;
      out_green_level   <= (run_cmd_r == KIND_MEAS) ? level_r[1] : '0;
      out_blue_level    <= (run_cmd_r == KIND_MEAS) ? level_r[2] : '0;
      out_white_level   <= white_max;
      out_white_missing <= white_zero;
    end
  end

endmodule

>>> hdl/cwb_ctrl.sv
// controller: transaction handshakes and end-of-run sequencing of the shared divider
module cwb_ctrl
  import cwb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  cwb_stat_t stat,
  output cwb_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_LOAD  = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_STORE = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [CH_W-1:0]   ch_r, ch_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    iter_nxt      = iter_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.ch        = ch_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (stat.run_done) begin
            ch_nxt    = '0;
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.div_load = 1'b1;
        iter_nxt     = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        iter_nxt     = iter_r + ITER_W'(1);
        if (iter_r == ITER_W'(NUM_W - 1)) state_nxt = ST_STORE;
      end
      ST_STORE: begin
        cmd.store = 1'b1;
        if (ch_r == CH_W'(NCH - 1)) begin
          state_nxt = ST_FIN;
        end else begin
          ch_nxt    = ch_r + CH_W'(1);
          state_nxt = ST_MUL;
        end
      end
      ST_FIN: begin
        // hold the new result until the output register is free
        if (out_free) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ch_r        <= '0;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      iter_r      <= iter_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || !out_stall))
    else $error("result loaded over a pending transaction");

  a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD) |-> ##(NUM_W + 1) (state_r == ST_STORE))
    else $error("divider did not run its full length");

  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_FIN))
    else $error("result raised outside the finish step");

  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mul || cmd.div_step || cmd.store) |-> in_stall)
    else $error("input open while the divider is busy");

endmodule

>>> hdl/color_white_balance_averager.sv
// top level of the white reference colour calibration averager
// Input channel: in_valid / in_stall carry one sensor sample per transaction, in_cmd
// tagging it as a calibration (white) or measurement sample; raw counts use the low
// CHANNEL_BITS bits. A change of in_cmd restarts the run.
// Output channel: out_valid / out_stall carry one result per completed run. A
// calibration result stores the truncated white averages and reports their maximum;
// a measurement result gives sum*255/(run*white) rounded and saturated at 255.
// Configuration: cfg_valid / cfg_ready write the calibration (index 0) and
// measurement (index 1) run lengths; cfg_ready is always high.
// A sample that does not end a run is taken without a stall. A sample that ends a
// run keeps in_stall high while the single restoring divider, one quotient bit a
// cycle, runs 34 steps per colour channel, plus one multiply, one load and one
// store step each, then a finish step that waits for the result register. The
// result register sits apart from the input, so samples keep flowing while a
// result waits on out_stall; only the next run end waits for the register to drain.
// Synchronous reset clears sums, count, stored whites and out_valid and restores
// the run lengths to 50 and 10.
module color_white_balance_averager
  import cwb_pkg::*;
#(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
  parameter int MAX_RUN      = MAX_RUN_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_cmd,
  input  logic [15:0]           in_red_raw,
  input  logic [15:0]           in_green_raw,
  input  logic [15:0]           in_blue_raw,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_result_kind,
  output logic [LEVEL_W-1:0]    out_red_level,
  output logic [LEVEL_W-1:0]    out_green_level,
  output logic [LEVEL_W-1:0]    out_blue_level,
  output logic [WHITE_W-1:0]    out_white_level,
  output logic                  out_white_missing,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cwb_cmd_t  cmd;
  cwb_stat_t stat;

  assign cfg_ready = 1'b1;

  cwb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  cwb_dp #(
    .CHANNEL_BITS (CHANNEL_BITS),
    .MAX_RUN      (MAX_RUN)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_write         (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_cmd            (in_cmd),
    .in_red_raw        (in_red_raw),
    .in_green_raw      (in_green_raw),
    .in_blue_raw       (in_blue_raw),
    .cmd               (cmd),
    .stat              (stat),
    .out_result_kind   (out_result_kind),
    .out_red_level     (out_red_level),
    .out_green_level   (out_green_level),
    .out_blue_level    (out_blue_level),
    .out_white_level   (out_white_level),
    .out_white_missing (out_white_missing)
  );

endmodule
